FILE: hdl/kca_pkg.sv
// Package for the keypad click and autorepeat decoder.
// Holds the scan and result word types, the key table and the register indexes.
// No dependencies.
package kca_pkg;

  localparam int unsigned KEY_COUNT = 14;
  localparam int unsigned KEY_W     = 4;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DELAY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_DELAY = 2'd1;

  localparam logic [15:0] FIRST_DELAY_RST  = 16'd500;
  localparam logic [15:0] REPEAT_DELAY_RST = 16'd175;

  // One bit per key: set when the key lives in group one.
  localparam logic [KEY_COUNT-1:0] KEY_IN_GROUP_ONE = 14'b10_0000_1110_0000;

  localparam logic [31:0] KEY_MASK [KEY_COUNT] = '{
    32'h0000_0010, 32'h0000_0020, 32'h0000_0080, 32'h0000_0040, 32'h0000_0100,
    32'hC000_0000, 32'h8000_0000, 32'h4000_0000, 32'h0000_0004, 32'h0000_0008,
    32'h0000_0200, 32'h0000_0400, 32'h0000_0800, 32'h0080_0000
  };

  typedef struct packed {
    logic [31:0] group_one_word;
    logic [15:0] group_two_word;
    logic [31:0] now_ms;
  } scan_word_t;

  typedef struct packed {
    logic [KEY_W-1:0] auto_key;
    logic [KEY_W-1:0] clicked_key;
    logic [KEY_W-1:0] pressed_key;
  } key_word_t;

  typedef struct packed {
    logic [KEY_COUNT-1:0] held;
    logic [KEY_W-1:0]     pressed;
    logic [KEY_W-1:0]     clicked;
  } key_scan_t;

  function automatic logic [KEY_COUNT-1:0] held_keys(input logic [31:0] w1,
                                                     input logic [15:0] w2);
    logic [KEY_COUNT-1:0] h;
    logic [31:0]          w;
    h = '0;
    for (int i = 0; i < KEY_COUNT; i++) begin
      w    = KEY_IN_GROUP_ONE[i] ? w1 : {16'd0, w2};
      h[i] = ((w & KEY_MASK[i]) == 32'd0);
    end
    return h;
  endfunction

endpackage

FILE: hdl/key_click_autorepeat.sv
// Keypad click and autorepeat decoder. A scan word is registered on acceptance and its
// result word is registered in the result register; one scan per cycle is sustained,
// with out_stall low, set by the single decode and repeat stage between the registers.
// Reset is synchronous and active low: it empties both stages, clears the previous scan
// and the autorepeat state, and loads the delays with 500 ms and 175 ms.
module key_click_autorepeat (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  kca_pkg::scan_word_t               in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output kca_pkg::key_word_t                out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [kca_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [15:0]                       cfg_data
);

  kca_pkg::scan_word_t s1_data_r;
  logic                s1_valid_r;
  kca_pkg::key_word_t  out_data_r;
  logic                out_valid_r;
  logic [31:0]         last_w1_r;
  logic [15:0]         last_w2_r;
  logic [15:0]         first_delay_r;
  logic [15:0]         repeat_delay_r;
  logic                advance;
  logic                accept;
  kca_pkg::key_scan_t  scan;
  logic [kca_pkg::KEY_W-1:0] auto_key;

  assign advance   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !advance;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  kca_decode u_decode (
    .w1      (s1_data_r.group_one_word),
    .w2      (s1_data_r.group_two_word),
    .last_w1 (last_w1_r),
    .last_w2 (last_w2_r),
    .scan    (scan)
  );

  kca_repeat u_repeat (
    .clk          (clk),
    .rst_n        (rst_n),
    .advance      (advance),
    .scan         (scan),
    .now_ms       (s1_data_r.now_ms),
    .first_delay  (first_delay_r),
    .repeat_delay (repeat_delay_r),
    .auto_key     (auto_key)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      last_w1_r   <= '0;
      last_w2_r   <= '0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        last_w1_r   <= s1_data_r.group_one_word;
        last_w2_r   <= s1_data_r.group_two_word;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_data_r <= in_data;
    end
    if (advance) begin
      out_data_r.auto_key    <= auto_key;
      out_data_r.clicked_key <= scan.clicked;
      out_data_r.pressed_key <= scan.pressed;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_delay_r  <= kca_pkg::FIRST_DELAY_RST;
      repeat_delay_r <= kca_pkg::REPEAT_DELAY_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        kca_pkg::CFG_FIRST_DELAY:  first_delay_r  <= cfg_data;
        kca_pkg::CFG_REPEAT_DELAY: repeat_delay_r <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

FILE: hdl/kca_decode.sv
// Key table decode: held keys, first pressed and first newly clicked key.
// Uses kca_pkg.
module kca_decode (
  input  logic [31:0]        w1,
  input  logic [15:0]        w2,
  input  logic [31:0]        last_w1,
  input  logic [15:0]        last_w2,
  output kca_pkg::key_scan_t scan
);

  logic [kca_pkg::KEY_COUNT-1:0] now_held;
  logic [kca_pkg::KEY_COUNT-1:0] was_held;
  logic [kca_pkg::KEY_COUNT-1:0] click_vec;

  assign now_held  = kca_pkg::held_keys(w1, w2);
  assign was_held  = kca_pkg::held_keys(last_w1, last_w2);
  assign click_vec = now_held & ~was_held;

  always_comb begin
    scan.held    = now_held;
    scan.pressed = '0;
    scan.clicked = '0;
    for (int i = kca_pkg::KEY_COUNT - 1; i >= 0; i--) begin
      if (now_held[i]) begin
        scan.pressed = kca_pkg::KEY_W'(i + 1);
      end
      if (click_vec[i]) begin
        scan.clicked = kca_pkg::KEY_W'(i + 1);
      end
    end
  end

endmodule

FILE: hdl/kca_repeat.sv
// Autorepeat state and decision for one scan at a time.
// Uses kca_pkg; fed by kca_decode.
module kca_repeat (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        advance,
  input  kca_pkg::key_scan_t          scan,
  input  logic [31:0]                 now_ms,
  input  logic [15:0]                 first_delay,
  input  logic [15:0]                 repeat_delay,
  output logic [kca_pkg::KEY_W-1:0]   auto_key
);

  logic [kca_pkg::KEY_W-1:0] repeat_key_r, repeat_key_nxt;
  logic                      repeated_once_r, repeated_once_nxt;
  logic [31:0]               last_event_r, last_event_nxt;
  logic [31:0]               diff;
  logic [15:0]               delay;
  logic                      rk_held;
  logic [kca_pkg::KEY_W-1:0] rk_idx;

  assign diff   = now_ms - last_event_r;
  assign delay  = repeated_once_r ? repeat_delay : first_delay;
  assign rk_idx = repeat_key_r - kca_pkg::KEY_W'(1);

  always_comb begin
    rk_held = 1'b0;
    if (repeat_key_r != '0 && repeat_key_r <= kca_pkg::KEY_W'(kca_pkg::KEY_COUNT)) begin
      rk_held = scan.held[rk_idx];
    end
  end

  always_comb begin
    repeat_key_nxt    = repeat_key_r;
    repeated_once_nxt = repeated_once_r;
    last_event_nxt    = last_event_r;
    auto_key          = '0;
    if (scan.clicked != '0) begin
      repeat_key_nxt    = scan.clicked;
      repeated_once_nxt = 1'b0;
      last_event_nxt    = now_ms;
      auto_key          = scan.clicked;
    end else if (rk_held) begin
      if (!diff[31] && diff > {16'd0, delay}) begin
        repeated_once_nxt = 1'b1;
        last_event_nxt    = now_ms;
        auto_key          = repeat_key_r;
      end
    end else begin
      repeat_key_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      repeat_key_r    <= '0;
      repeated_once_r <= 1'b0;
      last_event_r    <= '0;
    end else if (advance) begin
      repeat_key_r    <= repeat_key_nxt;
      repeated_once_r <= repeated_once_nxt;
      last_event_r    <= last_event_nxt;
    end
  end

endmodule

FILE: hdl/kca_checker.sv
// Port-level checks for the keypad click and autorepeat decoder.
// Uses kca_pkg; bound to key_click_autorepeat at the end of this file.
module kca_port_checks (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_stall,
  input kca_pkg::key_word_t            out_data
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Result valid right after reset.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("Stalled result word changed or dropped.");

  a_click_is_auto: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.clicked_key != '0 |-> out_data.auto_key == out_data.clicked_key)
    else $error("A click did not start autorepeat output.");

  a_click_pressed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.clicked_key != '0 |->
      out_data.pressed_key != '0 && out_data.pressed_key <= out_data.clicked_key)
    else $error("Clicked key not consistent with pressed key.");

  a_key_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.auto_key <= kca_pkg::KEY_W'(kca_pkg::KEY_COUNT) &&
                  out_data.pressed_key <= kca_pkg::KEY_W'(kca_pkg::KEY_COUNT))
    else $error("Key index out of table range.");

endmodule

bind key_click_autorepeat kca_port_checks u_port_checks (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

FILE: tb/sv/kca_checker.sv
// Checker for the keypad click and autorepeat decoder: watches the scan, result and
// register channels, predicts each key word and compares it with the block's output.
// Depends on kca_pkg for the word types and register indexes.
module kca_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  kca_pkg::scan_word_t           in_data,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  kca_pkg::key_word_t            out_data,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [kca_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_data,
  output int                            pending,
  output int                            errors,
  output int                            words_checked,
  output int                            clicks,
  output int                            repeats
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int KEY_GROUP [14] = '{2, 2, 2, 2, 2, 1, 1, 1, 2, 2, 2, 2, 2, 1};
  localparam logic [31:0] KEY_BITS [14] = '{
    32'h0000_0010, 32'h0000_0020, 32'h0000_0080, 32'h0000_0040, 32'h0000_0100,
    32'hC000_0000, 32'h8000_0000, 32'h4000_0000, 32'h0000_0004, 32'h0000_0008,
    32'h0000_0200, 32'h0000_0400, 32'h0000_0800, 32'h0080_0000
  };

  logic [15:0] first_delay;
  logic [15:0] repeat_delay;
  logic [31:0] prev_one;
  logic [15:0] prev_two;
  logic [3:0]  repeat_key;
  logic        repeated_once;
  logic [31:0] last_event_ms;

  kca_pkg::key_word_t expected_key_words [$];
  int        fail_count;
  int        match_count;
  int        click_count;
  int        repeat_count;

  function automatic bit key_is_held(input int idx, input logic [31:0] w1,
                                     input logic [15:0] w2);
    logic [31:0] w;
    w = (KEY_GROUP[idx] == 1) ? w1 : {16'd0, w2};
    return (w & KEY_BITS[idx]) == 32'd0;
  endfunction

  function automatic kca_pkg::key_word_t decode_scan(input kca_pkg::scan_word_t s);
    kca_pkg::key_word_t r;
    logic [31:0]        elapsed;
    logic [15:0]        hold_limit;
    r = '0;
    for (int i = 0; i < 14; i++) begin
      if (r.pressed_key == 4'd0 && key_is_held(i, s.group_one_word, s.group_two_word)) begin
        r.pressed_key = 4'(i + 1);
      end
      if (r.clicked_key == 4'd0 && key_is_held(i, s.group_one_word, s.group_two_word) &&
          !key_is_held(i, prev_one, prev_two)) begin
        r.clicked_key = 4'(i + 1);
      end
    end
    if (r.clicked_key != 4'd0) begin
      repeat_key    = r.clicked_key;
      repeated_once = 1'b0;
      last_event_ms = s.now_ms;
      r.auto_key    = r.clicked_key;
    end else if (repeat_key != 4'd0 &&
                 key_is_held(int'(repeat_key) - 1, s.group_one_word, s.group_two_word)) begin
      elapsed    = s.now_ms - last_event_ms;
      hold_limit = repeated_once ? repeat_delay : first_delay;
      // The elapsed time is read as signed: a negative difference never triggers a repeat.
      if (!elapsed[31] && elapsed > {16'd0, hold_limit}) begin
        repeated_once = 1'b1;
        last_event_ms = s.now_ms;
        r.auto_key    = repeat_key;
      end
    end else begin
      repeat_key = 4'd0;
    end
    prev_one = s.group_one_word;
    prev_two = s.group_two_word;
    return r;
  endfunction

  always @(posedge clk) begin
    kca_pkg::key_word_t want;
    if (!rst_n) begin
      first_delay   = kca_pkg::FIRST_DELAY_RST;
      repeat_delay  = kca_pkg::REPEAT_DELAY_RST;
      prev_one      = '0;
      prev_two      = '0;
      repeat_key    = '0;
      repeated_once = 1'b0;
      last_event_ms = '0;
      expected_key_words.delete();
      fail_count    = 0;
      match_count   = 0;
      click_count   = 0;
      repeat_count  = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          kca_pkg::CFG_FIRST_DELAY:  first_delay = cfg_data;
          kca_pkg::CFG_REPEAT_DELAY: repeat_delay = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        want = decode_scan(in_data);
        expected_key_words.push_back(want);
        if (want.clicked_key != 4'd0) begin
          click_count++;
        end else if (want.auto_key != 4'd0) begin
          repeat_count++;
        end
      end
      if (out_valid && !out_stall) begin
        if (expected_key_words.size() == 0) begin
          $error("key word %h arrived with none expected", out_data);
          fail_count++;
        end else begin
          want = expected_key_words.pop_front();
          match_count++;
          if (out_data.auto_key !== want.auto_key) begin
            $error("auto_key: expected %0d, got %0d", want.auto_key, out_data.auto_key);
            fail_count++;
          end
          if (out_data.clicked_key !== want.clicked_key) begin
            $error("clicked_key: expected %0d, got %0d", want.clicked_key,
                   out_data.clicked_key);
            fail_count++;
          end
          if (out_data.pressed_key !== want.pressed_key) begin
            $error("pressed_key: expected %0d, got %0d", want.pressed_key,
                   out_data.pressed_key);
            fail_count++;
          end
        end
      end
    end
    pending       <= expected_key_words.size();
    errors        <= fail_count + expected_key_words.size();
    words_checked <= match_count;
    clicks        <= click_count;
    repeats       <= repeat_count;
  end

endmodule

FILE: tb/sv/tb_key_click_autorepeat.sv
// Top of the keypad click and autorepeat testbench: clock, reset, scan and register
// stimulus under several delay settings and idle and stall patterns, and the final verdict.
// Depends on kca_pkg, the key_click_autorepeat block and the kca_checker module.
module tb_key_click_autorepeat;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int          RANDOM_ITEMS = 650;
  localparam int          PHASES       = 6;
  localparam logic [15:0] PHASE_FIRST  [PHASES] = '{16'd500, 16'd0, 16'd65535, 16'd3,
                                                    16'd1, 16'd40};
  localparam logic [15:0] PHASE_REPEAT [PHASES] = '{16'd175, 16'd0, 16'd65535, 16'd1,
                                                    16'd65535, 16'd7};
  localparam int DIRECTED_ORDER [14] = '{0, 1, 2, 3, 4, 6, 7, 5, 8, 9, 10, 11, 12, 13};

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  kca_pkg::scan_word_t           in_data = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  kca_pkg::key_word_t            out_data;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [kca_pkg::CFG_IDX_W-1:0] cfg_index = kca_pkg::CFG_FIRST_DELAY;
  logic [15:0]                   cfg_data = '0;

  int                  pending;
  int                  errors;
  int                  words_checked;
  int                  clicks;
  int                  repeats;
  int                  idle_pct = 0;
  int                  stall_pct = 0;
  int                  items_sent = 0;
  int                  directed_count;
  int unsigned         cycle_count = 0;
  int                  cur_first = 500;
  int                  cur_rep = 175;
  logic [31:0]         clock_ms = '0;
  kca_pkg::scan_word_t noise;

  key_click_autorepeat dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  kca_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .pending       (pending),
    .errors        (errors),
    .words_checked (words_checked),
    .clicks        (clicks),
    .repeats       (repeats)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("tb_key_click_autorepeat: done, errors");
      $finish;
    end
  end

  function automatic kca_pkg::scan_word_t key_scan(
      input logic [kca_pkg::KEY_COUNT-1:0] held, input logic [31:0] now);
    kca_pkg::scan_word_t s;
    s.group_one_word = $urandom;
    s.group_two_word = 16'($urandom);
    s.now_ms         = now;
    for (int i = 0; i < kca_pkg::KEY_COUNT; i++) begin
      if (kca_pkg::KEY_IN_GROUP_ONE[i]) begin
        s.group_one_word |= kca_pkg::KEY_MASK[i];
      end else begin
        s.group_two_word |= kca_pkg::KEY_MASK[i][15:0];
      end
    end
    for (int i = 0; i < kca_pkg::KEY_COUNT; i++) begin
      if (held[i] && kca_pkg::KEY_IN_GROUP_ONE[i]) begin
        s.group_one_word &= ~kca_pkg::KEY_MASK[i];
      end else if (held[i]) begin
        s.group_two_word &= ~kca_pkg::KEY_MASK[i][15:0];
      end
    end
    return s;
  endfunction

  function automatic logic [31:0] time_step(input int scan_no, input bit exact);
    int unsigned span;
    int unsigned pick;
    span = ((cur_first > cur_rep) ? cur_first : cur_rep) / 2 + 3;
    pick = $urandom_range(99);
    if (exact) begin
      if (scan_no == 0) begin
        return $urandom_range(50);
      end else if (scan_no == 1) begin
        return cur_first;
      end else if (scan_no % 2 == 1) begin
        return cur_rep;
      end
      return 32'd1;
    end
    if (pick < 70) begin
      return $urandom_range(span);
    end else if (pick < 85) begin
      return $urandom_range(3 * span);
    end else if (pick < 92) begin
      return 32'h8000_0000 + $urandom_range(1000);
    end
    return $urandom;
  endfunction

  task automatic send_scan(input kca_pkg::scan_word_t s);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_delays(input logic [15:0] first_ms, input logic [15:0] rep_ms);
    cfg_valid <= 1'b1;
    cfg_index <= kca_pkg::CFG_FIRST_DELAY;
    cfg_data  <= first_ms;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= kca_pkg::CFG_REPEAT_DELAY;
    cfg_data  <= rep_ms;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_first = int'(first_ms);
    cur_rep   = int'(rep_ms);
  endtask

  task automatic hold_sequence();
    logic [kca_pkg::KEY_COUNT-1:0] held;
    int                            key;
    int                            scans;
    bit                            exact;
    key   = $urandom_range(kca_pkg::KEY_COUNT - 1);
    scans = $urandom_range(12, 1);
    exact = ($urandom_range(3) == 0);
    if ($urandom_range(1) == 1) begin
      send_scan(key_scan('0, clock_ms));
    end
    for (int n = 0; n < scans; n++) begin
      held = '0;
      held[key] = 1'b1;
      if ($urandom_range(4) == 0) begin
        held |= kca_pkg::KEY_COUNT'($urandom);
      end
      clock_ms += time_step(n, exact);
      send_scan(key_scan(held, clock_ms));
    end
  endtask

  task automatic run_directed();
    logic [kca_pkg::KEY_COUNT-1:0] held;
    logic [31:0]                   t;
    // Every key reads as held on the first scan, so nothing clicks.
    send_scan('{group_one_word: '0, group_two_word: '0, now_ms: '0});
    send_scan('{group_one_word: '1, group_two_word: '1, now_ms: '1});
    send_scan('{group_one_word: '0, group_two_word: '0, now_ms: 32'd1000});
    clock_ms = 32'd1000;
    for (int i = 0; i < 14; i++) begin
      held = '0;
      held[DIRECTED_ORDER[i]] = 1'b1;
      clock_ms += 32'd10;
      send_scan(key_scan(held, clock_ms));
    end
    // Hold the last key across the exact delay limits and a backward time step.
    t = clock_ms;
    send_scan(key_scan(held, t + 32'd500));
    send_scan(key_scan(held, t + 32'd501));
    send_scan(key_scan(held, t + 32'd676));
    send_scan(key_scan(held, t + 32'd677));
    send_scan(key_scan(held, t + 32'd853));
    send_scan(key_scan(held, t + 32'd843));
    // A click just before the time count wraps, repeated just after it.
    held = 14'd4;
    send_scan(key_scan('0, 32'hFFFF_FFE0));
    send_scan(key_scan(held, 32'hFFFF_FFF0));
    send_scan(key_scan(held, 32'h0000_01F0));
    clock_ms = 32'h0000_01F0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    directed_count = items_sent;
    for (int p = 0; p < PHASES; p++) begin
      if (p != 0) begin
        drain();
        write_delays(PHASE_FIRST[p], PHASE_REPEAT[p]);
      end
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 59; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 59; end
        default: begin idle_pct = 15; stall_pct = 15; end
      endcase
      while (items_sent < directed_count + (p + 1) * RANDOM_ITEMS / PHASES) begin
        if ($urandom_range(9) == 0) begin
          clock_ms += $urandom_range(2000);
          noise.group_one_word = $urandom;
          noise.group_two_word = 16'($urandom);
          noise.now_ms         = clock_ms;
          send_scan(noise);
        end else begin
          hold_sequence();
        end
      end
    end
    drain();
    repeat (8) @(posedge clk);
    $display("Checked %0d key words from %0d scans over %0d delay settings.",
             words_checked, items_sent, PHASES);
    $display("Predicted %0d clicks and %0d autorepeats; %0d mismatches.",
             clicks, repeats, errors);
    if (errors == 0) begin
      $display("tb_key_click_autorepeat: done, clean");
    end else begin
      $display("tb_key_click_autorepeat: done, errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/kca_pkg.sv
hdl/kca_decode.sv
hdl/kca_repeat.sv
hdl/key_click_autorepeat.sv
hdl/kca_checker.sv
tb/sv/kca_checker.sv
tb/sv/tb_key_click_autorepeat.sv
